[rtl/ltmf_pkg.sv]
package ltmf_pkg;

   localparam int WINDOW_DEPTH = 10;
   localparam int TIME_W = 32;
   localparam int PERIOD_W = 24;
   localparam int DELAY_W = 23;
   localparam int PTR_W = $clog2(WINDOW_DEPTH);
   localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
   localparam int SUM_W = DELAY_W + $clog2(WINDOW_DEPTH);
   localparam int TRIM_DIV = WINDOW_DEPTH - 2;

   localparam logic [DELAY_W-1:0] EXCESS_CAP = DELAY_W'(20000 * 256 - 1);
   localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(8533);

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_ADDR_W-1:0] ADDR_PERIOD = '0;

   typedef struct packed {
      logic capture;
      logic take_first;
      logic diff;
      logic push;
      logic scan_step;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic awaiting_first;
      logic excess_positive;
      logic window_full;
      logic scan_last;
      logic out_free;
   } status_type;

endpackage

[rtl/ltmf_ctrl.sv]
module ltmf_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  ltmf_pkg::status_type status,
   output ltmf_pkg::cmd_type    cmd
);
   import ltmf_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_DIFF   = 5'b00010,
      ST_PUSH   = 5'b00100,
      ST_SCAN   = 5'b01000,
      ST_FINISH = 5'b10000
   } state_type;

   state_type state_ff;
   state_type state_in;

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in = ST_DIFF;
            end
         end
         ST_DIFF: begin
            if (status.awaiting_first) begin
               cmd.take_first = 1'b1;
               state_in = ST_IDLE;
            end else begin
               cmd.diff = 1'b1;
               state_in = ST_PUSH;
            end
         end
         ST_PUSH: begin
            if (!status.excess_positive) begin
               state_in = ST_IDLE;
            end else begin
               cmd.push = 1'b1;
               state_in = status.window_full ? ST_SCAN : ST_IDLE;
            end
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (status.scan_last) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[rtl/ltmf_datapath.sv]
module ltmf_datapath (
   input  logic                            clock,
   input  logic                            reset,
   input  ltmf_pkg::cmd_type               cmd,
   output ltmf_pkg::status_type            status,
   input  logic [ltmf_pkg::TIME_W-1:0]     arrival_time_q8,
   input  logic [ltmf_pkg::PERIOD_W-1:0]   expected_period_q8,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [ltmf_pkg::DELAY_W-1:0]    mean_delay_q8
);
   import ltmf_pkg::*;

   logic [TIME_W-1:0]  arrival_ff, arrival_in;
   logic [TIME_W-1:0]  ref_ff, ref_in;
   logic [TIME_W-1:0]  elapsed_ff, elapsed_in;
   logic               awaiting_ff, awaiting_in;
   logic [DELAY_W-1:0] ring_ff [WINDOW_DEPTH];
   logic [DELAY_W-1:0] ring_in [WINDOW_DEPTH];
   logic [PTR_W-1:0]   ptr_ff, ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [PTR_W-1:0]   idx_ff, idx_in;
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [DELAY_W-1:0] hi_ff, hi_in;
   logic [DELAY_W-1:0] lo_ff, lo_in;
   logic               valid_ff, valid_in;
   logic [DELAY_W-1:0] mean_ff, mean_in;

   logic [TIME_W-1:0]  period_ext;
   logic [TIME_W-1:0]  excess_raw;
   logic [DELAY_W-1:0] excess;
   logic [DELAY_W-1:0] tap;
   logic [SUM_W-1:0]   trimmed;
   logic [SUM_W-1:0]   quotient;

   assign period_ext = TIME_W'(expected_period_q8);
   assign excess_raw = elapsed_ff - period_ext;
   assign excess = (excess_raw > TIME_W'(EXCESS_CAP)) ? EXCESS_CAP
                                                      : excess_raw[DELAY_W-1:0];
   assign tap = ring_ff[idx_ff];
   assign trimmed = sum_ff - SUM_W'(hi_ff) - SUM_W'(lo_ff);
   assign quotient = trimmed / SUM_W'(TRIM_DIV);

   assign status.awaiting_first = awaiting_ff;
   assign status.excess_positive = (elapsed_ff > period_ext);
   assign status.window_full = (count_ff == CNT_W'(WINDOW_DEPTH));
   assign status.scan_last = (idx_ff == PTR_W'(WINDOW_DEPTH - 1));
   assign status.out_free = !valid_ff || !rsp_stall;

   assign rsp_valid = valid_ff;
   assign mean_delay_q8 = mean_ff;

   always_comb begin
      arrival_in = arrival_ff;
      ref_in = ref_ff;
      elapsed_in = elapsed_ff;
      awaiting_in = awaiting_ff;
      ring_in = ring_ff;
      ptr_in = ptr_ff;
      count_in = count_ff;
      idx_in = idx_ff;
      sum_in = sum_ff;
      hi_in = hi_ff;
      lo_in = lo_ff;
      valid_in = valid_ff;
      mean_in = mean_ff;

      if (cmd.capture) begin
         arrival_in = arrival_time_q8;
      end
      if (cmd.take_first) begin
         ref_in = arrival_ff;
         awaiting_in = 1'b0;
      end
      if (cmd.diff) begin
         elapsed_in = arrival_ff - ref_ff;
      end
      if (cmd.push) begin
         ring_in[ptr_ff] = excess;
         ptr_in = (ptr_ff == PTR_W'(WINDOW_DEPTH - 1)) ? '0 : ptr_ff + 1'b1;
         idx_in = '0;
         if (count_ff == CNT_W'(WINDOW_DEPTH)) begin
            ref_in = arrival_ff;
         end else begin
            count_in = count_ff + 1'b1;
         end
      end
      if (cmd.scan_step) begin
         idx_in = idx_ff + 1'b1;
         if (idx_ff == '0) begin
            sum_in = SUM_W'(tap);
            hi_in = tap;
            lo_in = tap;
         end else begin
            sum_in = sum_ff + SUM_W'(tap);
            if (tap > hi_ff) begin
               hi_in = tap;
            end
            if (tap < lo_ff) begin
               lo_in = tap;
            end
         end
      end
      if (cmd.emit) begin
         valid_in = 1'b1;
         mean_in = quotient[DELAY_W-1:0];
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_ff <= '0;
         awaiting_ff <= 1'b1;
         for (int i = 0; i < WINDOW_DEPTH; i++) begin
            ring_ff[i] <= '0;
         end
         ptr_ff <= '0;
         count_ff <= '0;
         idx_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         ref_ff <= ref_in;
         awaiting_ff <= awaiting_in;
         ring_ff <= ring_in;
         ptr_ff <= ptr_in;
         count_ff <= count_in;
         idx_ff <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      arrival_ff <= arrival_in;
      elapsed_ff <= elapsed_in;
      sum_ff <= sum_in;
      hi_ff <= hi_in;
      lo_ff <= lo_in;
      mean_ff <= mean_in;
   end

endmodule

[rtl/latency_trimmed_mean_filter_core.sv]
// Channel   Handshake                   Payload
// req       req_valid / req_stall       req_arrival_time_q8 [31:0]
// rsp       rsp_valid / rsp_stall       rsp_mean_delay_q8 [22:0]
// csr       psel penable pwrite pready  paddr [2:0], pwdata / prdata [31:0]
//
// An item that only latches the reference passes the idle and diff states; one
// that pushes nothing or only fills the ring passes the push state as well.
// An item that yields a result goes on through the ten-entry scan and finish
// states; the scan takes one entry per cycle through the sum, max and min unit.
// Reset is synchronous and active high and clears the ring to zeros at once.
// A stalled result holds in the output register; the next item is still taken,
// but its own result waits in the last state until the output register frees.
module latency_trimmed_mean_filter_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [ltmf_pkg::TIME_W-1:0]         req_arrival_time_q8,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [ltmf_pkg::DELAY_W-1:0]        rsp_mean_delay_q8,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [ltmf_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [ltmf_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [ltmf_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                                pready
);
   import ltmf_pkg::*;

   cmd_type              cmd;
   status_type           status;
   logic [PERIOD_W-1:0]  period_ff, period_in;

   assign pready = 1'b1;

   always_comb begin
      period_in = period_ff;
      if (psel && penable && pwrite && (paddr == ADDR_PERIOD)) begin
         period_in = pwdata[PERIOD_W-1:0];
      end
   end

   always_comb begin
      prdata = '0;
      if (paddr == ADDR_PERIOD) begin
         prdata = CSR_DATA_W'(period_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= PERIOD_RESET;
      end else begin
         period_ff <= period_in;
      end
   end

   ltmf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   ltmf_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .arrival_time_q8    (req_arrival_time_q8),
      .expected_period_q8 (period_ff),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .mean_delay_q8      (rsp_mean_delay_q8)
   );

endmodule
